// ===== sv/sorted_insert_priority_queue_top_defines.svh =====
// Assertion macros for the sorted insert priority queue.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted insert priority queue.
// No dependencies; imported by spq_store, spq_ctrl and the top level.
package spq_pkg;

  localparam int DEPTH  = 8;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;
  localparam int OCC_W  = 4;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic        [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } wr_t;

  typedef struct packed {
    status_t                  status;
    logic        [DATA_W-1:0] head_data;
    logic signed [PRIO_W-1:0] head_prio;
    logic        [OCC_W-1:0]  occupancy;
  } res_t;

endpackage

// ===== sv/spq_store.sv =====
// Entry storage for the priority queue: one write port, one registered read port.
// Depends on spq_pkg.
module spq_store (
  input  logic                      clk,
  input  spq_pkg::wr_t              wr,
  input  logic [spq_pkg::IDX_W-1:0] rd_addr,
  output spq_pkg::entry_t           rd_entry
);
  import spq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_entry_r;

  // Write one entry, register the read data
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_entry_r <= mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;

endmodule

// ===== sv/spq_ctrl.sv =====
// Sequencer of the priority queue: walks the sorted store one entry per step
// through a single signed compare. Depends on spq_pkg and the defines header.
`include "sorted_insert_priority_queue_top_defines.svh"

module spq_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic        [spq_pkg::DATA_W-1:0] in_item_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_item_priority,
  output logic                              res_valid,
  input  logic                              res_ready,
  output spq_pkg::res_t                     res,
  output spq_pkg::wr_t                      wr,
  output logic        [spq_pkg::IDX_W-1:0]  rd_addr,
  input  spq_pkg::entry_t                   rd_entry
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_HEAD,
    S_REM_MOV,
    S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic        [IDX_W-1:0]  idx_r, idx_nxt;
  logic        [CNT_W-1:0]  count_r, count_nxt;
  entry_t                   new_r, new_nxt;
  status_t                  status_r, status_nxt;
  logic        [DATA_W-1:0] head_data_r, head_data_nxt;
  logic signed [PRIO_W-1:0] head_prio_r, head_prio_nxt;
  logic                     prio_le;

  // Shared compare: new priority goes ahead of a stored one that is not smaller
  assign prio_le = (new_r.prio <= rd_entry.prio);

  // Next state and store accesses
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    new_nxt       = new_r;
    status_nxt    = status_r;
    head_data_nxt = head_data_r;
    head_prio_nxt = head_prio_r;
    wr            = '0;
    rd_addr       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_nxt.data  = in_item_data;
          new_nxt.prio  = in_item_priority;
          head_data_nxt = '0;
          head_prio_nxt = '0;
          status_nxt    = ST_OK;
          if (in_func == FUNC_INSERT) begin
            if (count_r == CNT_FULL) begin
              status_nxt = ST_OVERFLOW;
              state_nxt  = S_DONE;
            end else if (count_r == '0) begin
              wr.en         = 1'b1;
              wr.addr       = '0;
              wr.entry.data = in_item_data;
              wr.entry.prio = in_item_priority;
              count_nxt     = count_r + 1'b1;
              state_nxt     = S_DONE;
            end else begin
              idx_nxt   = IDX_W'(count_r);
              rd_addr   = IDX_W'(count_r - 1'b1);
              state_nxt = S_INS_CMP;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_UNDERFLOW;
              state_nxt  = S_DONE;
            end else begin
              rd_addr   = '0;
              state_nxt = S_REM_HEAD;
            end
          end
        end
      end
      S_INS_CMP: begin
        if (prio_le) begin
          // Shift the stored entry up one slot and look further down
          wr.en    = 1'b1;
          wr.addr  = idx_r;
          wr.entry = rd_entry;
          idx_nxt  = idx_r - 1'b1;
          if (idx_r == IDX_W'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            rd_addr = idx_r - 1'b1 - 1'b1;
          end
        end else begin
          wr.en     = 1'b1;
          wr.addr   = idx_r;
          wr.entry  = new_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_INS_PUT: begin
        wr.en     = 1'b1;
        wr.addr   = idx_r;
        wr.entry  = new_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_REM_HEAD: begin
        head_data_nxt = rd_entry.data;
        head_prio_nxt = rd_entry.prio;
        if (count_r == CNT_W'(1)) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = IDX_W'(1);
          rd_addr   = IDX_W'(1);
          state_nxt = S_REM_MOV;
        end
      end
      S_REM_MOV: begin
        // Move each entry one slot toward the head
        wr.en    = 1'b1;
        wr.addr  = idx_r - 1'b1;
        wr.entry = rd_entry;
        if (idx_r == IDX_W'(count_r - 1'b1)) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r       <= idx_nxt;
    new_r       <= new_nxt;
    status_r    <= status_nxt;
    head_data_r <= head_data_nxt;
    head_prio_r <= head_prio_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_DONE);
  assign res.status    = status_r;
  assign res.head_data = head_data_r;
  assign res.head_prio = head_prio_r;
  assign res.occupancy = OCC_W'(count_r);

  `SPQ_ASSERT(a_count_bound, count_r <= CNT_FULL, "entry count above depth")
  `SPQ_ASSERT_IMPL(a_no_write_idle, state_r == S_DONE || (state_r == S_IDLE && !in_valid), !wr.en, "store written while idle")
  `SPQ_ASSERT_IMPL(a_underflow_empty, res_valid && status_r == ST_UNDERFLOW, count_r == '0, "underflow reported with stored entries")
  `SPQ_ASSERT_IMPL(a_overflow_full, res_valid && status_r == ST_OVERFLOW, count_r == CNT_FULL, "overflow reported on a queue that is not full")

endmodule

// ===== sv/sorted_insert_priority_queue_top.sv =====
// Top level of the sorted insert priority queue: sequencer, store and result register.
// Depends on spq_pkg, spq_store and spq_ctrl.
//
//  channel | ports                                                   | direction
//  in      | in_valid/in_ready, in_func, in_item_data, in_item_priority | into block
//  out     | out_valid/out_ready, out_status, out_head_data,          | out of block
//          | out_head_priority, out_occupancy                         |
//
// Insert shifts entries at or above the new priority up a slot, then writes the new one;
// overflow and an empty queue skip the walk. Remove takes the head, moving the rest down.
// The loop is set by the store's single registered read port and the one priority compare.
// Reset clears the state and the entry count only; stored entries need no clearing pass.
// A new item is taken while the previous result still waits in the output register.
module sorted_insert_priority_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic        [31:0] in_item_data,
  input  logic signed [15:0] in_item_priority,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [1:0]  out_status,
  output logic        [31:0] out_head_data,
  output logic signed [15:0] out_head_priority,
  output logic        [3:0]  out_occupancy
);
  import spq_pkg::*;

  wr_t              wr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;
  res_t             res;
  logic             res_valid;
  logic             res_ready;
  logic             out_valid_r;
  res_t             out_r;

  spq_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  spq_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res),
    .wr               (wr),
    .rd_addr          (rd_addr),
    .rd_entry         (rd_entry)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_head_data     = out_r.head_data;
  assign out_head_priority = out_r.head_prio;
  assign out_occupancy     = out_r.occupancy;

endmodule
